// ===== src/ssa_pkg.sv =====
// Package for the slab slot allocator: field widths, codes and state encoding.
// No dependencies; imported by ssa_div, slab_slot_allocator and tb_top.
package ssa_pkg;

  localparam int unsigned DEF_MAX_SLOTS = 256;

  localparam int unsigned ADDR_W      = 39;
  localparam int unsigned CFG_SIZE_W  = 16;
  localparam int unsigned CFG_COUNT_W = 9;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 56;

  // Bitmap row geometry
  localparam int unsigned ROW_W  = 16;
  localparam int unsigned ROW_LW = 4;

  // An in-range offset is below count * size, so it fits in these bits
  localparam int unsigned DIVIDEND_W = CFG_SIZE_W + CFG_COUNT_W;

  typedef enum logic [0:0] {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_OUTSIDE  = 2'd2,
    STAT_NOT_USED = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_SIZE  = 2'd0,
    REG_SLOT_COUNT = 2'd1,
    REG_BASE_ADDR  = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_A_MUL,
    ST_A_ADD,
    ST_F_LIM,
    ST_F_RNG,
    ST_F_DIV,
    ST_F_RD,
    ST_F_CHK,
    ST_OUT
  } state_e;

endpackage

// ===== src/ssa_div.sv =====
// Restoring divider, one quotient bit per cycle, for slot index lookup.
// Depends on ssa_pkg; the quotient must fit in IDX_W bits.
module ssa_div #(
  parameter int unsigned IDX_W = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ssa_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  logic [ssa_pkg::CFG_SIZE_W-1:0]   divisor_i,
  output logic                             done_o,
  output logic [IDX_W-1:0]                 quotient_o
);
  import ssa_pkg::*;

  localparam int unsigned CMP_W = DIVIDEND_W + IDX_W;
  localparam int unsigned SC_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;

  logic             busy_q;
  logic             done_q;
  logic [SC_W-1:0]  step_q;
  logic [CMP_W-1:0] rem_q;
  logic [CMP_W-1:0] dsh_q;
  logic [IDX_W-1:0] quo_q;
  logic             ge;

  assign ge = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= SC_W'(IDX_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= CMP_W'(dividend_i);
      dsh_q <= CMP_W'(divisor_i) << (IDX_W - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[IDX_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/slab_slot_allocator.sv =====
// Slab slot allocator top level: bitmap memory, sequencer and result register.
// Depends on ssa_pkg and ssa_div.
//
// Channel  Dir  Handshake              Payload
// s_axis   in   tvalid/tready          tuser mode, tdata address
// m_axis   out  tvalid/tready          tuser status, tdata object/free/full
// cfg      in   cfg_we_i, no wait      cfg_idx_i register, cfg_data_i value
//
// Allocate: reads and checks one 16-slot bitmap row at a time, then multiply and add steps on a hit.
// Free: limit, range check, the bit-serial divider for the slot index, then bitmap read and clear.
// A free outside the slab skips the divider; an allocate on an empty slab goes straight to output.
// After reset the bitmap is cleared one row per cycle, over all ceil(MAX_SLOTS/16) rows.
// One beat in flight; a finished result waits in the output register.
module slab_slot_allocator #(
  parameter int unsigned MAX_SLOTS = ssa_pkg::DEF_MAX_SLOTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ssa_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // address[38:0], pad
  input  logic [0:0]                       s_axis_tuser,   // mode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ssa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // object_address[38:0],
                                                           // free_slots[47:39],
                                                           // full_res[48], pad
  output logic [ssa_pkg::STATUS_W-1:0]     m_axis_tuser,   // status
  input  logic                             cfg_we_i,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ssa_pkg::ADDR_W-1:0]       cfg_data_i
);
  import ssa_pkg::*;

  localparam int unsigned NROWS = (MAX_SLOTS + ROW_W - 1) / ROW_W;
  localparam int unsigned RW    = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int unsigned IW    = RW + ROW_LW;
  localparam int unsigned UW    = $clog2(MAX_SLOTS + 1);
  localparam int unsigned PW    = IW + CFG_SIZE_W;

  state_e                 state_q, state_d;
  logic [CFG_SIZE_W-1:0]  cfg_size_q;
  logic [CFG_COUNT_W-1:0] cfg_count_q;
  logic [ADDR_W-1:0]      cfg_base_q;
  logic [UW-1:0]          used_q;
  logic [RW-1:0]          row_q;
  logic                   out_valid_q;

  logic [IW-1:0]          idx_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [ADDR_W-1:0]      off_q;
  logic [DIVIDEND_W-1:0]  lim_q;
  logic                   below_q;
  logic [PW-1:0]          prod_q;
  status_e                status_q;
  logic [ADDR_W-1:0]      obj_q;

  status_e                out_status_q;
  logic [ADDR_W-1:0]      out_obj_q;
  logic [CFG_COUNT_W-1:0] out_free_q;
  logic                   out_full_q;

  logic [ROW_W-1:0]       mem_q [NROWS];
  logic [ROW_W-1:0]       rdata_q;
  logic                   mem_we;
  logic [RW-1:0]          mem_waddr;
  logic [RW-1:0]          mem_raddr;
  logic [ROW_W-1:0]       mem_wdata;

  logic [CFG_SIZE_W-1:0]  size_eff;
  logic [CFG_COUNT_W-1:0] cnt_eff;
  logic [CFG_COUNT_W-1:0] free_now;
  logic                   in_accept;
  logic                   load_out;
  logic                   hit;
  logic [ROW_LW-1:0]      hit_bit;
  logic                   last_row;
  logic                   in_range;
  logic                   free_bit;
  logic                   div_start;
  logic                   div_done;
  logic [IW-1:0]          div_quo;

  assign size_eff = (cfg_size_q == '0) ? CFG_SIZE_W'(1) : cfg_size_q;
  assign cnt_eff  = (32'(cfg_count_q) > MAX_SLOTS) ? CFG_COUNT_W'(MAX_SLOTS) : cfg_count_q;
  assign free_now = (32'(used_q) >= 32'(cnt_eff)) ? '0
                  : CFG_COUNT_W'(32'(cnt_eff) - 32'(used_q));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
  assign last_row      = ((32'(row_q) + 32'd1) << ROW_LW) >= 32'(cnt_eff);
  assign in_range      = !below_q && (off_q < ADDR_W'(lim_q));
  assign free_bit      = rdata_q[idx_q[ROW_LW-1:0]];

  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (!rdata_q[b] && (32'({row_q, ROW_LW'(b)}) < 32'(cnt_eff))) begin
        hit     = 1'b1;
        hit_bit = ROW_LW'(b);
      end
    end
  end

  ssa_div #(
    .IDX_W(IW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (off_q[DIVIDEND_W-1:0]),
    .divisor_i  (size_eff),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (row_q == RW'(NROWS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_accept) begin
          if (mode_e'(s_axis_tuser) == MODE_FREE) begin
            state_d = ST_F_LIM;
          end else if (cnt_eff == '0) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_A_RD;
          end
        end
      end
      ST_A_RD:  state_d = ST_A_CHK;
      ST_A_CHK: begin
        if (hit) begin
          state_d = ST_A_MUL;
        end else if (last_row) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_A_RD;
        end
      end
      ST_A_MUL: state_d = ST_A_ADD;
      ST_A_ADD: state_d = ST_OUT;
      ST_F_LIM: state_d = ST_F_RNG;
      ST_F_RNG: state_d = in_range ? ST_F_DIV : ST_OUT;
      ST_F_DIV: if (div_done) state_d = ST_F_RD;
      ST_F_RD:  state_d = ST_F_CHK;
      ST_F_CHK: state_d = ST_OUT;
      ST_OUT:   if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_q;
    mem_raddr = row_q;
    mem_wdata = rdata_q;
    div_start = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      ST_A_CHK: begin
        mem_we    = hit;
        mem_wdata = rdata_q | (ROW_W'(1) << hit_bit);
      end
      ST_F_RNG: div_start = in_range;
      ST_F_RD:  mem_raddr = idx_q[IW-1:ROW_LW];
      ST_F_CHK: begin
        mem_waddr = idx_q[IW-1:ROW_LW];
        mem_we    = free_bit;
        mem_wdata = rdata_q & ~(ROW_W'(1) << idx_q[ROW_LW-1:0]);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cfg_size_q  <= CFG_SIZE_W'(16);
      cfg_count_q <= CFG_COUNT_W'(256);
      cfg_base_q  <= '0;
      used_q      <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_SLOT_SIZE:  cfg_size_q  <= cfg_data_i[CFG_SIZE_W-1:0];
          REG_SLOT_COUNT: cfg_count_q <= cfg_data_i[CFG_COUNT_W-1:0];
          REG_BASE_ADDR:  cfg_base_q  <= cfg_data_i;
          default:        cfg_base_q  <= cfg_base_q;
        endcase
      end
      case (state_q)
        ST_CLEAR: row_q <= row_q + 1'b1;
        ST_IDLE:  row_q <= '0;
        ST_A_CHK: begin
          if (hit) begin
            used_q <= used_q + 1'b1;
          end else begin
            row_q <= row_q + 1'b1;
          end
        end
        ST_F_CHK: begin
          if (free_bit && (used_q != '0)) begin
            used_q <= used_q - 1'b1;
          end
        end
        default: row_q <= row_q;
      endcase
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        addr_q   <= s_axis_tdata[ADDR_W-1:0];
        obj_q    <= '0;
        status_q <= (mode_e'(s_axis_tuser) == MODE_ALLOC && cnt_eff == '0)
                    ? STAT_FULL : STAT_OK;
      end
      ST_A_CHK: begin
        if (hit) begin
          idx_q <= {row_q, hit_bit};
        end else if (last_row) begin
          status_q <= STAT_FULL;
        end
      end
      ST_A_MUL: prod_q <= PW'(idx_q) * PW'(size_eff);
      ST_A_ADD: obj_q  <= cfg_base_q + ADDR_W'(prod_q);
      ST_F_LIM: begin
        off_q   <= addr_q - cfg_base_q;
        below_q <= addr_q < cfg_base_q;
        lim_q   <= DIVIDEND_W'(cnt_eff) * DIVIDEND_W'(size_eff);
      end
      ST_F_RNG: if (!in_range) status_q <= STAT_OUTSIDE;
      ST_F_DIV: if (div_done) idx_q <= div_quo;
      ST_F_CHK: if (!free_bit) status_q <= STAT_NOT_USED;
      default:  obj_q <= obj_q;
    endcase
    if (load_out) begin
      out_status_q <= status_q;
      out_obj_q    <= obj_q;
      out_free_q   <= free_now;
      out_full_q   <= (free_now == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_full_q, out_free_q, out_obj_q});

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for slab_slot_allocator: drives allocate and free beats, predicts each
// result in a scoreboard class and checks the results in order of arrival.
// Depends on ssa_pkg and the slab_slot_allocator RTL.
module tb_top;
  import ssa_pkg::*;

  localparam int unsigned       SLOTS    = DEF_MAX_SLOTS;
  localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

  typedef struct {
    status_e                status;
    logic [ADDR_W-1:0]      obj;
    logic [CFG_COUNT_W-1:0] free;
    logic                   full;
  } answer_t;

  class slab_tracker;
    bit                     in_use [SLOTS];
    int unsigned            used;
    logic [CFG_SIZE_W-1:0]  size_reg;
    logic [CFG_COUNT_W-1:0] count_reg;
    logic [ADDR_W-1:0]      base_reg;
    answer_t                pending_answers [$];
    int unsigned            errors;
    int unsigned            requests;
    int unsigned            results;
    int unsigned            status_seen [4];

    function new();
      used      = 0;
      size_reg  = CFG_SIZE_W'(16);
      count_reg = CFG_COUNT_W'(256);
      base_reg  = '0;
      errors    = 0;
      requests  = 0;
      results   = 0;
      foreach (in_use[i]) in_use[i] = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_reg(reg_e idx, logic [ADDR_W-1:0] value);
      case (idx)
        REG_SLOT_SIZE:  size_reg  = value[CFG_SIZE_W-1:0];
        REG_SLOT_COUNT: count_reg = value[CFG_COUNT_W-1:0];
        REG_BASE_ADDR:  base_reg  = value;
        default: ;
      endcase
    endfunction

    function int unsigned slot_bytes();
      return (size_reg == 0) ? 1 : size_reg;
    endfunction

    function int unsigned live_slots();
      return (count_reg > SLOTS) ? SLOTS : count_reg;
    endfunction

    function void note_request(mode_e mode, logic [ADDR_W-1:0] addr);
      answer_t     a;
      int unsigned sz;
      int unsigned cnt;
      int unsigned idx;
      int unsigned left;
      logic [63:0] top;
      logic [63:0] entry;
      bit          found;
      sz       = slot_bytes();
      cnt      = live_slots();
      a.status = STAT_OK;
      a.obj    = '0;
      idx      = 0;
      if (mode == MODE_ALLOC) begin
        found = 1'b0;
        for (int i = 0; i < cnt && !found; i++) begin
          if (!in_use[i]) begin
            found = 1'b1;
            idx   = i;
          end
        end
        if (found) begin
          in_use[idx] = 1'b1;
          used++;
          a.obj = ADDR_W'(64'(base_reg) + 64'(idx) * 64'(sz));
        end else begin
          a.status = STAT_FULL;
        end
      end else begin
        top = 64'(base_reg) + 64'(cnt) * 64'(sz);
        if (addr < base_reg || 64'(addr) >= top) begin
          a.status = STAT_OUTSIDE;
        end else begin
          entry = (64'(addr) - 64'(base_reg)) / 64'(sz);
          if (entry >= cnt || !in_use[entry]) begin
            a.status = STAT_NOT_USED;
          end else begin
            in_use[entry] = 1'b0;
            if (used > 0) used--;
          end
        end
      end
      left   = (used >= cnt) ? 0 : cnt - used;
      a.free = left[CFG_COUNT_W-1:0];
      a.full = (left == 0);
      pending_answers.push_back(a);
      requests++;
    endfunction

    function void check_result(status_e st, logic [ADDR_W-1:0] obj,
                               logic [CFG_COUNT_W-1:0] free, logic full);
      answer_t a;
      results++;
      status_seen[st]++;
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: status %0d object %h free %0d full %b",
                 $time, st, obj, free, full);
        return;
      end
      a = pending_answers.pop_front();
      if (st !== a.status) begin
        errors++;
        $display("%0t: status expected %0d, actual %0d", $time, a.status, st);
      end
      if (obj !== a.obj) begin
        errors++;
        $display("%0t: object_address expected %h, actual %h", $time, a.obj, obj);
      end
      if (free !== a.free) begin
        errors++;
        $display("%0t: free_slots expected %0d, actual %0d", $time, a.free, free);
      end
      if (full !== a.full) begin
        errors++;
        $display("%0t: full_res expected %b, actual %b", $time, a.full, full);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic [0:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [ADDR_W-1:0]      cfg_data_i;

  slab_tracker book = new();
  bit          calm = 1'b0;
  int unsigned settings = 0;

  slab_slot_allocator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 32);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      book.check_result(status_e'(m_axis_tuser), m_axis_tdata[ADDR_W-1:0],
                        m_axis_tdata[ADDR_W+CFG_COUNT_W-1:ADDR_W],
                        m_axis_tdata[ADDR_W+CFG_COUNT_W]);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_req(input mode_e mode, input logic [ADDR_W-1:0] addr);
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {1'b0, addr};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    book.note_request(mode, addr);
    @(negedge clk_i);
  endtask

  // Hold the input idle until every result has been taken.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (book.pending_answers.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [ADDR_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    book.set_reg(idx, value);
  endtask

  task automatic apply_setting(input logic [CFG_SIZE_W-1:0] size,
                               input logic [CFG_COUNT_W-1:0] count,
                               input logic [ADDR_W-1:0] base);
    settle();
    write_reg(REG_SLOT_SIZE, ADDR_W'(size));
    write_reg(REG_SLOT_COUNT, ADDR_W'(count));
    write_reg(REG_BASE_ADDR, base);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // Random allocates and frees; the frees mostly hit slots inside the slab, the rest bounds and noise.
  task automatic random_phase(input int unsigned items);
    int unsigned       alloc_pct;
    int unsigned       cnt;
    int unsigned       sz;
    int unsigned       idx;
    int unsigned       off;
    logic [63:0]       top;
    logic [ADDR_W-1:0] addr;
    alloc_pct = $urandom_range(25, 75);
    for (int n = 0; n < items; n++) begin
      cnt  = book.live_slots();
      sz   = book.slot_bytes();
      top  = 64'(book.base_reg) + 64'(cnt) * 64'(sz);
      addr = ADDR_W'({$urandom, $urandom});
      if ($urandom_range(99) < alloc_pct) begin
        send_req(MODE_ALLOC, addr);
      end else begin
        case ($urandom_range(9))
          0: ;
          1: begin
            case ($urandom_range(2))
              0: addr = book.base_reg - 1'b1;
              1: addr = ADDR_W'(top);
              default: addr = ADDR_W'(top - 64'd1);
            endcase
          end
          default: begin
            if (cnt > 0) begin
              idx = $urandom_range(cnt - 1);
              for (int t = 0; t < 4 && !book.in_use[idx]; t++) idx = $urandom_range(cnt - 1);
              off  = $urandom_range(1) ? 0 : $urandom_range(sz - 1);
              addr = ADDR_W'(64'(book.base_reg) + 64'(idx) * 64'(sz) + 64'(off));
            end
          end
        endcase
        send_req(MODE_FREE, addr);
      end
    end
  endtask

  initial begin
    logic [CFG_SIZE_W-1:0]  r_size;
    logic [CFG_COUNT_W-1:0] r_count;
    logic [ADDR_W-1:0]      r_base;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_ALLOC;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_SLOT_SIZE;
    cfg_data_i    = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setting: 16-byte slots, 256 of them, base zero
    send_req(MODE_FREE, 39'd0);
    send_req(MODE_ALLOC, ADDR_TOP);
    send_req(MODE_ALLOC, 39'd0);
    send_req(MODE_ALLOC, 39'h2A_AAAA_AAAA);
    send_req(MODE_FREE, 39'd17);
    send_req(MODE_FREE, 39'd17);
    send_req(MODE_ALLOC, 39'd0);
    send_req(MODE_FREE, 39'd4096);
    send_req(MODE_FREE, ADDR_TOP);
    send_req(MODE_FREE, 39'd4095);

    // zero size and zero count: empty slab
    apply_setting(16'd0, 9'd0, 39'd5);
    send_req(MODE_ALLOC, 39'd5);
    send_req(MODE_FREE, 39'd5);

    // size 32768, base near the top so slot addresses wrap
    apply_setting(16'd32768, 9'd8, ADDR_TOP - 39'd65535);
    send_req(MODE_ALLOC, 39'd0);
    send_req(MODE_FREE, ADDR_TOP - 39'd65536);
    send_req(MODE_FREE, ADDR_TOP - 39'd65535 + 39'd32868);
    send_req(MODE_ALLOC, 39'd0);
    send_req(MODE_ALLOC, 39'd0);

    // count above capacity, one-byte slots
    apply_setting(16'd1, 9'd511, 39'd0);
    send_req(MODE_ALLOC, 39'd0);
    send_req(MODE_FREE, 39'd256);
    send_req(MODE_FREE, 39'd255);
    send_req(MODE_FREE, 39'd4);

    // count lowered below marked slots
    apply_setting(16'd65535, 9'd2, 39'd0);
    send_req(MODE_ALLOC, 39'd0);
    send_req(MODE_FREE, 39'd196605);
    send_req(MODE_FREE, 39'd65536);
    send_req(MODE_ALLOC, 39'd0);

    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(5))
        0: r_size = 16'd0;
        1: r_size = 16'd1;
        2: r_size = $urandom_range(1) ? 16'd32768 : 16'hFFFF;
        3: r_size = CFG_SIZE_W'($urandom_range(2, 64));
        default: r_size = CFG_SIZE_W'($urandom_range(16'hFFFF));
      endcase
      case ($urandom_range(6))
        0: r_count = 9'd256;
        1: r_count = CFG_COUNT_W'($urandom_range(257, 511));
        2: r_count = CFG_COUNT_W'($urandom_range(3));
        default: r_count = CFG_COUNT_W'($urandom_range(2, 24));
      endcase
      case ($urandom_range(3))
        0: r_base = '0;
        1: r_base = ADDR_TOP - ADDR_W'($urandom_range(4096));
        default: r_base = ADDR_W'({$urandom, $urandom});
      endcase
      apply_setting(r_size, r_count, r_base);
      calm <= (p == 4);
      random_phase(103);
    end
    settle();

    $display("Covered %0d requests under %0d register settings; %0d results checked.",
             book.requests, settings + 1, book.results);
    $display("Result status mix: ok %0d, full %0d, outside %0d, not in use %0d.",
             book.status_seen[STAT_OK], book.status_seen[STAT_FULL],
             book.status_seen[STAT_OUTSIDE], book.status_seen[STAT_NOT_USED]);
    if (book.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding.", book.pending_answers.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
src/ssa_pkg.sv
src/ssa_div.sv
src/slab_slot_allocator.sv
verif/tb_top.sv
